// ===== rtl/dbam_pkg.sv =====
// ----------------------------------------------------------------------------
// dbam_pkg
// shared types and constants for the disk block allocation map
// ----------------------------------------------------------------------------
package dbam_pkg;

    localparam int TRACK_COUNT_DEF = 80;
    localparam int SECTORS_DEF     = 40;

    // system track sectors below this one are reserved
    localparam int FIRST_SPARE   = 4;
    localparam int RESERVED_LAST = 3;

    localparam int LOAD_MAP_W = 40;

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_LOAD  = 2'd2;
    localparam logic [1:0] KIND_NOP   = 2'd3;

    typedef struct packed {
        logic [1:0]            kind;
        logic [7:0]            track;
        logic [7:0]            sector;
        logic [7:0]            load_count;
        logic [LOAD_MAP_W-1:0] load_map;
    } req_t;

    typedef struct packed {
        logic       ok;
        logic [6:0] got_track;
        logic [5:0] got_sector;
    } rsp_t;

endpackage

// ===== rtl/dbam_store.sv =====
// ----------------------------------------------------------------------------
// dbam_store
// per-track free map and free count, one read and one write port, with a
// valid bit per track so that unwritten tracks read as a blank disk
// ----------------------------------------------------------------------------
module dbam_store #(
    parameter int TRACK_COUNT       = dbam_pkg::TRACK_COUNT_DEF,
    parameter int SECTORS_PER_TRACK = dbam_pkg::SECTORS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [$clog2(TRACK_COUNT)-1:0]        rd_addr,
    output logic [SECTORS_PER_TRACK+7:0]          rd_entry,
    input  logic                                  wr_en,
    input  logic [$clog2(TRACK_COUNT)-1:0]        wr_addr,
    input  logic [SECTORS_PER_TRACK+7:0]          wr_entry
);

    localparam int AW       = $clog2(TRACK_COUNT);
    localparam int EW       = SECTORS_PER_TRACK + 8;
    localparam int SYS_LAST = TRACK_COUNT / 2 - 1;
    localparam logic [SECTORS_PER_TRACK-1:0] SPARE_MASK =
        SECTORS_PER_TRACK'(2 ** dbam_pkg::FIRST_SPARE - 1);

    logic [EW-1:0]          mem [TRACK_COUNT];
    logic [EW-1:0]          mem_q_reg;
    logic [AW-1:0]          rd_addr_reg;
    logic [TRACK_COUNT-1:0] valid_reg;
    logic                   hit_valid_reg;

    logic [SECTORS_PER_TRACK-1:0] blank_map;
    logic [7:0]                   blank_count;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        mem_q_reg   <= mem[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            hit_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            hit_valid_reg <= valid_reg[rd_addr];
        end
    end

    // blank-format contents of the track just read
    always_comb
    begin
        if (rd_addr_reg == AW'(SYS_LAST))
        begin
            blank_map   = ~SPARE_MASK;
            blank_count = 8'(SECTORS_PER_TRACK - dbam_pkg::FIRST_SPARE);
        end
        else
        begin
            blank_map   = '1;
            blank_count = 8'(SECTORS_PER_TRACK);
        end
    end

    assign rd_entry = hit_valid_reg ? mem_q_reg : {blank_count, blank_map};

endmodule

// ===== rtl/disk_block_allocation_map.sv =====
// ----------------------------------------------------------------------------
// disk_block_allocation_map
// free sector allocator over a per-track bitmap and free count
// ----------------------------------------------------------------------------
//   channel   signals                      direction   width
//   request   req_valid, req_stall, req    in          2+8+8+8+40
//   response  rsp_valid, rsp_stall, rsp    out         1+7+6
//
// load, refused and no-op requests answer straight from idle; free reads the track entry, then answers
// allocate scans the tracks: one track entry is read from the
// store per cycle, upper tracks first, system track last
// reset is asynchronous; per-track valid bits make the store read as a blank
// disk right away, with no clearing pass
// a new request is taken only when idle and the response register is free
// or being taken in the same cycle
module disk_block_allocation_map #(
    parameter int TRACK_COUNT       = dbam_pkg::TRACK_COUNT_DEF,
    parameter int SECTORS_PER_TRACK = dbam_pkg::SECTORS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  dbam_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output dbam_pkg::rsp_t  rsp
);

    localparam int SPT      = SECTORS_PER_TRACK;
    localparam int AW       = $clog2(TRACK_COUNT);
    localparam int SW       = $clog2(SPT);
    localparam int EW       = SPT + 8;
    localparam int SYS_ADDR = TRACK_COUNT / 2;
    localparam int SYS_LAST = TRACK_COUNT / 2 - 1;
    localparam logic [SPT-1:0] SPARE_MASK = SPT'(2 ** dbam_pkg::FIRST_SPARE - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FREE = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    function automatic logic [SW-1:0] encode(input logic [SPT-1:0] oh);
        logic [SW-1:0] r;
        r = '0;
        for (int i = 0; i < SPT; i++)
        begin
            if (oh[i])
            begin
                r = r | SW'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a);
        return (a == AW'(TRACK_COUNT - 1)) ? '0 : AW'(a + 1'b1);
    endfunction

    logic [1:0]     state_reg, state_next;
    logic [AW-1:0]  cur_addr_reg, cur_addr_next;
    logic [AW-1:0]  scan_addr_reg, scan_addr_next;
    logic [SW-1:0]  sec_reg, sec_next;
    logic           rsp_valid_reg, rsp_valid_next;
    dbam_pkg::rsp_t rsp_reg, rsp_next;

    logic           accept;
    logic           rsp_taken;
    logic           trk_ok, sec_ok, reserved;
    logic [AW-1:0]  trk_addr;
    logic [63:0]    lmap_ext;

    logic [AW-1:0]  rd_addr;
    logic [EW-1:0]  rd_entry;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [EW-1:0]  wr_entry;

    logic [SPT-1:0] cur_map, cand, isolate, sec_bit;
    logic [7:0]     cur_count;
    logic           last_track, scan_hit;
    logic [7:0]     got_trk_w;

    dbam_store #(
        .TRACK_COUNT       (TRACK_COUNT),
        .SECTORS_PER_TRACK (SECTORS_PER_TRACK)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry)
    );

    assign rsp_taken = rsp_valid_reg && !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;

    assign trk_ok   = (req.track != 8'd0) && (req.track <= 8'(TRACK_COUNT));
    assign trk_addr = AW'(req.track - 8'd1);
    assign sec_ok   = req.sector < 8'(SPT);
    assign reserved = (trk_addr == AW'(SYS_LAST))
                      && (req.sector <= 8'(dbam_pkg::RESERVED_LAST));
    assign lmap_ext = 64'(req.load_map);

    assign cur_map   = rd_entry[SPT-1:0];
    assign cur_count = rd_entry[EW-1:SPT];

    // the system track is the last resort: spare sectors only, count ignored
    assign last_track = cur_addr_reg == AW'(SYS_LAST);
    assign cand       = last_track ? (cur_map & ~SPARE_MASK) : cur_map;
    assign isolate    = cand & (~cand + 1'b1);
    assign scan_hit   = (cand != '0) && (last_track || cur_count != 8'd0);
    assign got_trk_w  = 8'(cur_addr_reg) + 8'd1;
    assign sec_bit    = SPT'(1) << sec_reg;

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: rd_addr = (req.kind == dbam_pkg::KIND_FREE) ? trk_addr : AW'(SYS_ADDR);
            ST_SCAN: rd_addr = scan_addr_reg;
            default: rd_addr = cur_addr_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_addr_next  = cur_addr_reg;
        scan_addr_next = scan_addr_reg;
        sec_next       = sec_reg;
        rsp_valid_next = rsp_taken ? 1'b0 : rsp_valid_reg;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = cur_addr_reg;
        wr_entry       = rd_entry;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.kind)
                        dbam_pkg::KIND_ALLOC:
                        begin
                            state_next     = ST_SCAN;
                            cur_addr_next  = AW'(SYS_ADDR);
                            scan_addr_next = next_addr(AW'(SYS_ADDR));
                        end
                        dbam_pkg::KIND_FREE:
                        begin
                            if (trk_ok && sec_ok && !reserved)
                            begin
                                state_next    = ST_FREE;
                                cur_addr_next = trk_addr;
                                sec_next      = SW'(req.sector);
                            end
                            else
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next       = '0;
                            end
                        end
                        dbam_pkg::KIND_LOAD:
                        begin
                            wr_en          = trk_ok;
                            wr_addr        = trk_addr;
                            wr_entry       = {req.load_count, lmap_ext[SPT-1:0]};
                            rsp_valid_next = 1'b1;
                            rsp_next       = '0;
                            rsp_next.ok    = trk_ok;
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next       = '0;
                        end
                    endcase
                end
            end
            ST_FREE:
            begin
                // already free: answer ok and leave the entry alone
                wr_en          = (cur_map & sec_bit) == '0;
                wr_entry       = {cur_count + 8'd1, cur_map | sec_bit};
                rsp_valid_next = 1'b1;
                rsp_next       = '0;
                rsp_next.ok    = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    wr_en               = 1'b1;
                    wr_entry            = {cur_count - 8'd1, cur_map & ~isolate};
                    rsp_valid_next      = 1'b1;
                    rsp_next.ok         = 1'b1;
                    rsp_next.got_track  = got_trk_w[6:0];
                    rsp_next.got_sector = 6'(encode(isolate));
                    state_next          = ST_IDLE;
                end
                else if (last_track)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cur_addr_next  = scan_addr_reg;
                    scan_addr_next = next_addr(scan_addr_reg);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_addr_reg  <= cur_addr_next;
        scan_addr_reg <= scan_addr_next;
        sec_reg       <= sec_next;
        rsp_reg       <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // a store write during the scan always comes with a successful response
    a_scan_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && wr_en) |=> (rsp_valid_reg && rsp_reg.ok))
        else $error("scan write without successful response");

    // the scan only gives up on the system track
    a_scan_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && !scan_hit && !last_track) |=> (state_reg == ST_SCAN))
        else $error("scan ended early");

    // every new response leaves the sequencer idle
    a_rsp_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> (state_reg == ST_IDLE))
        else $error("response while busy");

    // scan address stays inside the track range
    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cur_addr_reg < AW'(TRACK_COUNT - 1)
                                    || cur_addr_reg == AW'(TRACK_COUNT - 1)))
        else $error("scan address out of range");

endmodule
